// File: hw/rtl/indexed_array_list_unit_macros.svh
// ----------------------------------------------------------------------------
// Indexed array list assertion macros
// Shared concurrent assertion forms, sampled on clk and muted during reset.
// ----------------------------------------------------------------------------
`ifndef INDEXED_ARRAY_LIST_UNIT_MACROS_SVH
`define INDEXED_ARRAY_LIST_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Check that cons holds in the same cycle as ante.
`define IAL_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle check");

// Check that cons holds in the cycle after ante.
`define IAL_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle check");

`else

`define IAL_ASSERT_NOW(label, ante, cons)
`define IAL_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: hw/rtl/ial_pkg.sv
// ----------------------------------------------------------------------------
// Indexed array list package
// Command and result payloads, codes and the control bundles shared by the
// cell chain, the match scanner and the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ial_pkg;

	// Command codes
	localparam logic [2:0] CMD_INSERT = 3'd0;
	localparam logic [2:0] CMD_DELETE = 3'd1;
	localparam logic [2:0] CMD_UPDATE = 3'd2;
	localparam logic [2:0] CMD_READ   = 3'd3;
	localparam logic [2:0] CMD_FIND   = 3'd4;
	localparam logic [2:0] CMD_SORT   = 3'd5;

	// Status codes
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_RANGE    = 2'd1;
	localparam logic [1:0] STAT_FULL     = 2'd2;
	localparam logic [1:0] STAT_NOTFOUND = 2'd3;

	typedef struct packed {
		logic [2:0]         command;
		logic [6:0]         position;
		logic signed [31:0] value;
	} cmd_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] read_value;
		logic [6:0]         found_index;
		logic [7:0]         count;
		logic               is_empty;
		logic               is_full;
	} rsp_t;

	// Per-cycle operation broadcast to every cell
	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_DELETE,
		CELL_UPDATE,
		CELL_SORT
	} cell_op_t;

	typedef struct packed {
		cell_op_t           op;
		logic [6:0]         position;
		logic signed [31:0] value;
		logic               phase;
	} cell_ctl_t;

	// Match scanner result
	typedef struct packed {
		logic       done;
		logic       found;
		logic [6:0] index;
	} scan_res_t;

	typedef enum logic [2:0] {
		FSM_IDLE,
		FSM_EXEC,
		FSM_FIND,
		FSM_SORT,
		FSM_HOLD
	} fsm_t;

endpackage

// File: hw/rtl/ial_stream_if.sv
// ----------------------------------------------------------------------------
// Valid/ready stream interface
// One channel: valid, ready and a payload of any packed type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ial_stream_if #(
	parameter type payload_t = logic
) ();

	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);

endinterface

// File: hw/rtl/ial_cell.sv
// ----------------------------------------------------------------------------
// Indexed array list cell
// Holds one list entry; shifts with its neighbors on insert and delete and
// does one odd-even compare-exchange step with a neighbor during sort.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ial_cell #(
	parameter int CAPACITY = 128,
	parameter int INDEX    = 0
) (
	input  logic                              clk,
	input  ial_pkg::cell_ctl_t                ctl,
	input  logic [$clog2(CAPACITY+1)-1:0]     count,
	input  logic signed [31:0]                left,
	input  logic signed [31:0]                right,
	output logic signed [31:0]                data,
	output logic                              match,
	output logic signed [31:0]                rd
);

	import ial_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int EW = (CW > 7) ? CW : 7;
	localparam logic [EW-1:0] IDX  = EW'(INDEX);
	localparam logic [EW-1:0] IDX1 = EW'(INDEX + 1);
	localparam logic          PAR  = 1'(INDEX % 2);

	logic signed [31:0] data_q;
	logic signed [31:0] data_d;
	logic [EW-1:0]      pos_e;
	logic [EW-1:0]      cnt_e;

	assign pos_e = EW'(ctl.position);
	assign cnt_e = EW'(count);

	// Pick the next entry value
	always_comb begin
		data_d = data_q;
		unique case (ctl.op)
			CELL_INSERT: begin
				if (IDX == pos_e) begin
					data_d = ctl.value;
				end else if (IDX > pos_e && IDX <= cnt_e) begin
					data_d = left;
				end
			end
			CELL_DELETE: begin
				if (IDX >= pos_e && IDX1 < cnt_e) begin
					data_d = right;
				end
			end
			CELL_UPDATE: begin
				if (IDX == pos_e) begin
					data_d = ctl.value;
				end
			end
			CELL_SORT: begin
				// lower cell of a pair keeps the minimum, upper keeps the maximum
				if (PAR == ctl.phase && IDX1 < cnt_e) begin
					data_d = (right < data_q) ? right : data_q;
				end else if (PAR != ctl.phase && INDEX > 0 && IDX < cnt_e) begin
					data_d = (data_q < left) ? left : data_q;
				end
			end
			default: begin
				data_d = data_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data  = data_q;
	assign match = (data_q == ctl.value) && (IDX < cnt_e);
	assign rd    = (IDX == pos_e) ? data_q : 32'sd0;

endmodule

// File: hw/rtl/ial_find_scan.sv
// ----------------------------------------------------------------------------
// Indexed array list match scanner
// Takes the match flags of all cells and walks them sixteen at a time to
// find the lowest matching index.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ial_find_scan #(
	parameter int CAPACITY = 128
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [CAPACITY-1:0]  flags,
	output ial_pkg::scan_res_t   res
);

	import ial_pkg::*;

	localparam int G  = 16;
	localparam int NG = (CAPACITY + G - 1) / G;
	localparam int VW = NG * G;
	localparam int GW = (NG > 1) ? $clog2(NG) : 1;

	logic [VW-1:0] vec_q;
	logic [GW-1:0] grp_q;
	logic          busy_q;
	logic          hit;
	logic          last;
	logic [3:0]    pe;

	// Lowest set bit of the current group
	always_comb begin
		pe = 4'd0;
		for (int k = G - 1; k >= 0; k--) begin
			if (vec_q[k]) begin
				pe = 4'(k);
			end
		end
	end

	assign hit  = |vec_q[G-1:0];
	assign last = (grp_q == GW'(NG - 1));

	assign res.done  = busy_q && (hit || last);
	assign res.found = busy_q && hit;
	assign res.index = 7'({grp_q, pe});

	// Track scan progress
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			grp_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			grp_q  <= '0;
		end else if (busy_q) begin
			if (hit || last) begin
				busy_q <= 1'b0;
			end else begin
				grp_q <= grp_q + GW'(1);
			end
		end
	end

	// Load and advance the flag vector
	always_ff @(posedge clk) begin
		if (start) begin
			vec_q <= VW'(flags);
		end else if (busy_q) begin
			vec_q <= vec_q >> G;
		end
	end

endmodule

// File: hw/rtl/indexed_array_list_unit.sv
// ----------------------------------------------------------------------------
// Indexed array list unit
// Ordered list of signed 32-bit entries kept in a chain of cells, with
// insert, delete, update, read, find and sort commands.
// ----------------------------------------------------------------------------
// Usage:
//   cmd (sink) carries command, position and value; rsp (source) returns one
//   result per command: status, read_value, found_index, count, is_empty and
//   is_full. Commands are taken one at a time; the next is taken only once
//   the current one has finished and its result is in the output register.
//   Command handling:
//     insert, delete, update, read and unused codes: finish in the exec state.
//     find: the scanner checks sixteen cell match flags per cycle and stops
//       at the first hit.
//     sort: when count > 1, one odd-even compare-exchange round of the cell
//       chain per cycle.
//   Each command leaves the entries in the cells, and every cell takes its
//   next value from itself, the command or a neighbor.
//   Reset empties the list at once (count 0); entries are not cleared.
//   A finished result sits in the output register; if that is still full,
//   the unit holds the result and takes no new command until it is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "indexed_array_list_unit_macros.svh"

module indexed_array_list_unit #(
	parameter int CAPACITY = 128
) (
	input  logic          clk,
	input  logic          arst_n,
	ial_stream_if.sink    cmd,
	ial_stream_if.source  rsp
);

	import ial_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int EW = (CW > 7) ? CW : 7;
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	fsm_t          state_q;
	fsm_t          state_d;
	cmd_t          cmd_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] count_d;
	logic [CW-1:0] round_q;
	rsp_t          res_d;
	rsp_t          res_q;
	rsp_t          rsp_q;
	logic          rsp_valid_q;
	logic          out_free;
	logic          finish;
	logic          scan_start;
	cell_ctl_t     ctl;
	scan_res_t     scan_res;
	logic [EW-1:0] pos_e;
	logic [EW-1:0] cnt_e;
	logic signed [31:0] rd_bus;

	logic signed [31:0]  cell_data [CAPACITY];
	logic signed [31:0]  cell_rd   [CAPACITY];
	logic [CAPACITY-1:0] cell_match;

	assign pos_e    = EW'(cmd_q.position);
	assign cnt_e    = EW'(count_q);
	assign out_free = !rsp_valid_q || rsp.ready;

	// Cell chain
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [31:0] left_w;
		logic signed [31:0] right_w;

		if (i == 0) begin : g_first
			assign left_w = 32'sd0;
		end else begin : g_mid_l
			assign left_w = cell_data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_w = 32'sd0;
		end else begin : g_mid_r
			assign right_w = cell_data[i+1];
		end

		ial_cell #(
			.CAPACITY (CAPACITY),
			.INDEX    (i)
		) u_cell (
			.clk   (clk),
			.ctl   (ctl),
			.count (count_q),
			.left  (left_w),
			.right (right_w),
			.data  (cell_data[i]),
			.match (cell_match[i]),
			.rd    (cell_rd[i])
		);
	end

	// Gather the addressed entry
	always_comb begin
		rd_bus = 32'sd0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_bus = rd_bus | cell_rd[i];
		end
	end

	ial_find_scan #(
		.CAPACITY (CAPACITY)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (scan_start),
		.flags   (cell_match),
		.res     (scan_res)
	);

	// Next state, cell operation and result
	always_comb begin
		state_d             = state_q;
		count_d             = count_q;
		finish              = 1'b0;
		scan_start          = 1'b0;
		ctl.op              = CELL_HOLD;
		ctl.position        = cmd_q.position;
		ctl.value           = cmd_q.value;
		ctl.phase           = round_q[0];
		res_d.status        = STAT_OK;
		res_d.read_value    = 32'sd0;
		res_d.found_index   = 7'd0;

		unique case (state_q)
			FSM_IDLE: begin
				if (cmd.valid) begin
					state_d = FSM_EXEC;
				end
			end
			FSM_EXEC: begin
				unique case (cmd_q.command)
					CMD_INSERT: begin
						finish = 1'b1;
						if (count_q == CAP_C) begin
							res_d.status = STAT_FULL;
						end else if (pos_e > cnt_e) begin
							res_d.status = STAT_RANGE;
						end else begin
							ctl.op  = CELL_INSERT;
							count_d = count_q + CW'(1);
						end
					end
					CMD_DELETE: begin
						finish = 1'b1;
						if (pos_e >= cnt_e) begin
							res_d.status = STAT_RANGE;
						end else begin
							ctl.op  = CELL_DELETE;
							count_d = count_q - CW'(1);
						end
					end
					CMD_UPDATE: begin
						finish = 1'b1;
						if (pos_e >= cnt_e) begin
							res_d.status = STAT_RANGE;
						end else begin
							ctl.op = CELL_UPDATE;
						end
					end
					CMD_READ: begin
						finish = 1'b1;
						if (pos_e >= cnt_e) begin
							res_d.status = STAT_RANGE;
						end else begin
							res_d.read_value = rd_bus;
						end
					end
					CMD_FIND: begin
						scan_start = 1'b1;
						state_d    = FSM_FIND;
					end
					CMD_SORT: begin
						if (count_q > CW'(1)) begin
							state_d = FSM_SORT;
						end else begin
							finish = 1'b1;
						end
					end
					default: begin
						finish = 1'b1;
					end
				endcase
			end
			FSM_FIND: begin
				if (scan_res.done) begin
					finish = 1'b1;
					if (scan_res.found) begin
						res_d.found_index = scan_res.index;
					end else begin
						res_d.status = STAT_NOTFOUND;
					end
				end
			end
			FSM_SORT: begin
				ctl.op = CELL_SORT;
				if (round_q == count_q - CW'(1)) begin
					finish = 1'b1;
				end
			end
			FSM_HOLD: begin
				if (out_free) begin
					state_d = FSM_IDLE;
				end
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase

		if (finish) begin
			state_d = out_free ? FSM_IDLE : FSM_HOLD;
		end

		res_d.count    = 8'(count_d);
		res_d.is_empty = (count_d == '0);
		res_d.is_full  = (count_d == CAP_C);
	end

	assign cmd.ready   = (state_q == FSM_IDLE);
	assign rsp.valid   = rsp_valid_q;
	assign rsp.payload = rsp_q;

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= FSM_IDLE;
			count_q     <= '0;
			round_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (state_q == FSM_SORT) begin
				round_q <= round_q + CW'(1);
			end else begin
				round_q <= '0;
			end
			if ((finish || state_q == FSM_HOLD) && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			cmd_q <= cmd.payload;
		end
		if (finish) begin
			res_q <= res_d;
		end
		if (finish && out_free) begin
			rsp_q <= res_d;
		end else if (state_q == FSM_HOLD && out_free) begin
			rsp_q <= res_q;
		end
	end

	// Checks
	`IAL_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CAP_C)
	`IAL_ASSERT_NEXT(a_accept_exec, cmd.valid && cmd.ready, state_q == FSM_EXEC)
	`IAL_ASSERT_NOW(a_sort_round, state_q == FSM_SORT, round_q < count_q)
	`IAL_ASSERT_NEXT(a_finish_out, finish && out_free, rsp_valid_q)

endmodule
